FILE: hdl/bda_pkg.sv
// Package for the bounded dynamic array: sizes, field widths, codes and
// the control structs shared by the controller and the datapath.
// No dependencies.
package bda_pkg;

  // Storage geometry
  localparam int DEPTH      = 64;
  localparam int DATA_WIDTH = 32;
  localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LEN_W      = $clog2(DEPTH + 1);

  // Item field widths
  localparam int CMD_W   = 3;
  localparam int INDEX_W = 6;
  localparam int DIN_W   = 32;
  localparam int NLEN_W  = 7;
  localparam int RDATA_W = 32;
  localparam int CLEN_W  = 7;
  localparam int ERR_W   = 3;

  // Common width for comparing lengths and indexes
  localparam int CMP_W = ((LEN_W > NLEN_W) ? LEN_W : NLEN_W) + 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_READ   = 3'd0,
    CMD_WRITE  = 3'd1,
    CMD_PUSH   = 3'd2,
    CMD_POP    = 3'd3,
    CMD_RESIZE = 3'd4
  } cmd_e;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK        = 3'd0,
    ERR_BOUNDS    = 3'd1,
    ERR_FULL      = 3'd2,
    ERR_EMPTY     = 3'd3,
    ERR_TOO_LARGE = 3'd4
  } err_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_FILL,
    S_HOLD
  } state_e;

  // Which source feeds the result register
  typedef enum logic [1:0] {
    RES_NOW,
    RES_READ,
    RES_FILL,
    RES_PEND
  } res_sel_e;

  typedef struct packed {
    logic     accept;
    logic     fill_step;
    logic     load_out;
    logic     save_pend;
    res_sel_e res_sel;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_read;
    logic needs_fill;
    logic fill_last;
  } ctrl_sts_t;

  typedef struct packed {
    logic [RDATA_W-1:0] data;
    logic [LEN_W-1:0]   len;
    err_e               err;
  } res_t;

endpackage

FILE: hdl/bda_in_if.sv
// Input channel of the bounded dynamic array: valid/ready and one command item.
// Depends on bda_pkg for field widths.
interface bda_in_if;
  logic                        valid;
  logic                        ready;
  logic [bda_pkg::CMD_W-1:0]   command;
  logic [bda_pkg::INDEX_W-1:0] index;
  logic [bda_pkg::DIN_W-1:0]   data_in;
  logic [bda_pkg::NLEN_W-1:0]  target_len;
  logic                        enable;

  modport source (output valid, command, index, data_in, target_len, enable, input ready);
  modport sink   (input valid, command, index, data_in, target_len, enable, output ready);
endinterface

FILE: hdl/bda_out_if.sv
// Output channel of the bounded dynamic array: valid/ready and one result item.
// Depends on bda_pkg for field widths.
interface bda_out_if;
  logic                        valid;
  logic                        ready;
  logic [bda_pkg::RDATA_W-1:0] read_data;
  logic [bda_pkg::CLEN_W-1:0]  current_length;
  logic [bda_pkg::ERR_W-1:0]   error_code;

  modport source (output valid, read_data, current_length, error_code, input ready);
  modport sink   (input valid, read_data, current_length, error_code, output ready);
endinterface

FILE: hdl/bda_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module bda_ram #(
  parameter  int WIDTH = 32,
  parameter  int DEPTH = 64,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/bda_datapath.sv
// Datapath of the bounded dynamic array: length register, bounds checks,
// element store, fill pointer and the pending and output result registers.
// Depends on bda_pkg and bda_ram.
module bda_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bda_pkg::ctrl_cmd_t            cmd_i,
  output bda_pkg::ctrl_sts_t            sts_o,
  input  logic [bda_pkg::CMD_W-1:0]     command_i,
  input  logic [bda_pkg::INDEX_W-1:0]   index_i,
  input  logic [bda_pkg::DIN_W-1:0]     data_in_i,
  input  logic [bda_pkg::NLEN_W-1:0]    target_len_i,
  input  logic                          enable_i,
  output logic [bda_pkg::RDATA_W-1:0]   read_data_o,
  output logic [bda_pkg::CLEN_W-1:0]    current_length_o,
  output logic [bda_pkg::ERR_W-1:0]     error_code_o
);

  logic [bda_pkg::LEN_W-1:0]      len_q, len_d;
  logic [bda_pkg::LEN_W-1:0]      ptr_q, ptr_inc;
  logic [bda_pkg::LEN_W-1:0]      req_q;
  logic [bda_pkg::DATA_WIDTH-1:0] data_q;
  bda_pkg::err_e                  err_q;
  logic                           rd_ok_q;
  bda_pkg::res_t                  pend_q, out_q, res;

  logic                           idx_ok, is_full, is_empty, req_ok, grow;
  logic [bda_pkg::LEN_W-1:0]      now_len;
  bda_pkg::err_e                  now_err;
  logic                           wr_en;
  logic [bda_pkg::ADDR_W-1:0]     wr_addr, idx_addr;

  logic                           ram_we;
  logic [bda_pkg::ADDR_W-1:0]     ram_waddr;
  logic [bda_pkg::DATA_WIDTH-1:0] ram_wdata, ram_rdata;

  // Bounds checks against the current length
  assign idx_ok   = bda_pkg::CMP_W'(index_i) < bda_pkg::CMP_W'(len_q);
  assign is_full  = bda_pkg::CMP_W'(len_q) >= bda_pkg::CMP_W'(bda_pkg::DEPTH);
  assign is_empty = (len_q == '0);
  assign req_ok   = bda_pkg::CMP_W'(target_len_i) <= bda_pkg::CMP_W'(bda_pkg::DEPTH);
  assign grow     = req_ok && (bda_pkg::CMP_W'(target_len_i) > bda_pkg::CMP_W'(len_q));
  assign idx_addr = bda_pkg::ADDR_W'(index_i);

  // Decode the incoming item: error, new length and store write
  always_comb begin
    now_len = len_q;
    now_err = bda_pkg::ERR_OK;
    wr_en   = 1'b0;
    wr_addr = idx_addr;
    case (command_i)
      bda_pkg::CMD_READ: begin
        if (!idx_ok) now_err = bda_pkg::ERR_BOUNDS;
      end
      bda_pkg::CMD_WRITE: begin
        if (idx_ok) wr_en = 1'b1;
        else        now_err = bda_pkg::ERR_BOUNDS;
      end
      bda_pkg::CMD_PUSH: begin
        if (is_full) begin
          now_err = bda_pkg::ERR_FULL;
        end else begin
          wr_en   = 1'b1;
          wr_addr = len_q[bda_pkg::ADDR_W-1:0];
          now_len = len_q + bda_pkg::LEN_W'(enable_i);
        end
      end
      bda_pkg::CMD_POP: begin
        if (is_empty) now_err = bda_pkg::ERR_EMPTY;
        else          now_len = len_q - bda_pkg::LEN_W'(enable_i);
      end
      bda_pkg::CMD_RESIZE: begin
        if (!req_ok)    now_err = bda_pkg::ERR_TOO_LARGE;
        else if (!grow) now_len = bda_pkg::LEN_W'(target_len_i);
      end
      default: begin
      end
    endcase
  end

  // Status to the controller
  assign ptr_inc = ptr_q + bda_pkg::LEN_W'(1);
  always_comb begin
    sts_o.is_read    = (command_i == bda_pkg::CMD_READ);
    sts_o.needs_fill = (command_i == bda_pkg::CMD_RESIZE) && grow;
    sts_o.fill_last  = (ptr_inc == req_q);
  end

  // Store write port: fill steps take priority over item writes
  always_comb begin
    if (cmd_i.fill_step) begin
      ram_we    = 1'b1;
      ram_waddr = ptr_q[bda_pkg::ADDR_W-1:0];
      ram_wdata = data_q;
    end else begin
      ram_we    = cmd_i.accept && wr_en;
      ram_waddr = wr_addr;
      ram_wdata = bda_pkg::DATA_WIDTH'(data_in_i);
    end
  end

  bda_ram #(
    .WIDTH (bda_pkg::DATA_WIDTH),
    .DEPTH (bda_pkg::DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (idx_addr),
    .rdata_o (ram_rdata)
  );

  // Select the result source
  always_comb begin
    case (cmd_i.res_sel)
      bda_pkg::RES_NOW: begin
        res.data = '0;
        res.len  = now_len;
        res.err  = now_err;
      end
      bda_pkg::RES_READ: begin
        res.data = rd_ok_q ? bda_pkg::RDATA_W'(ram_rdata) : '0;
        res.len  = len_q;
        res.err  = err_q;
      end
      bda_pkg::RES_FILL: begin
        res.data = '0;
        res.len  = req_q;
        res.err  = bda_pkg::ERR_OK;
      end
      default: begin
        res = pend_q;
      end
    endcase
  end

  // Length register: update on accept, jump to the target at fill end
  always_comb begin
    len_d = len_q;
    if (cmd_i.accept)                          len_d = now_len;
    else if (cmd_i.fill_step && sts_o.fill_last) len_d = req_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else begin
      len_q <= len_d;
    end
  end

  // Latch item fields, advance fill pointer, hold results
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      data_q  <= bda_pkg::DATA_WIDTH'(data_in_i);
      req_q   <= bda_pkg::LEN_W'(target_len_i);
      ptr_q   <= len_q;
      err_q   <= now_err;
      rd_ok_q <= idx_ok;
    end else if (cmd_i.fill_step) begin
      ptr_q <= ptr_inc;
    end
    if (cmd_i.save_pend) pend_q <= res;
    if (cmd_i.load_out)  out_q  <= res;
  end

  assign read_data_o      = out_q.data;
  assign current_length_o = bda_pkg::CLEN_W'(out_q.len);
  assign error_code_o     = out_q.err;

endmodule

FILE: hdl/bda_controller.sv
// Controller of the bounded dynamic array: state machine for accept, read
// wait, resize fill and result hold, plus the output valid flag.
// Depends on bda_pkg.
module bda_controller (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  bda_pkg::ctrl_sts_t  sts_i,
  output bda_pkg::ctrl_cmd_t  cmd_o
);

  bda_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic            out_free;
  logic            accept;
  logic            finish;

  assign out_free = !out_valid_q || out_ready_i;
  assign accept   = (state_q == bda_pkg::S_IDLE) && in_valid_i;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      bda_pkg::S_IDLE: begin
        if (accept) begin
          if (sts_i.is_read)         state_d = bda_pkg::S_READ;
          else if (sts_i.needs_fill) state_d = bda_pkg::S_FILL;
          else if (!out_free)        state_d = bda_pkg::S_HOLD;
        end
      end
      bda_pkg::S_READ: begin
        state_d = out_free ? bda_pkg::S_IDLE : bda_pkg::S_HOLD;
      end
      bda_pkg::S_FILL: begin
        if (sts_i.fill_last) state_d = out_free ? bda_pkg::S_IDLE : bda_pkg::S_HOLD;
      end
      bda_pkg::S_HOLD: begin
        if (out_free) state_d = bda_pkg::S_IDLE;
      end
      default: begin
        state_d = bda_pkg::S_IDLE;
      end
    endcase
  end

  // Command outputs
  always_comb begin
    cmd_o.accept    = accept;
    cmd_o.fill_step = 1'b0;
    cmd_o.res_sel   = bda_pkg::RES_NOW;
    finish          = 1'b0;
    case (state_q)
      bda_pkg::S_IDLE: begin
        finish = accept && !sts_i.is_read && !sts_i.needs_fill;
      end
      bda_pkg::S_READ: begin
        cmd_o.res_sel = bda_pkg::RES_READ;
        finish        = 1'b1;
      end
      bda_pkg::S_FILL: begin
        cmd_o.fill_step = 1'b1;
        cmd_o.res_sel   = bda_pkg::RES_FILL;
        finish          = sts_i.fill_last;
      end
      bda_pkg::S_HOLD: begin
        cmd_o.res_sel = bda_pkg::RES_PEND;
      end
      default: begin
      end
    endcase
    if (state_q == bda_pkg::S_HOLD) begin
      cmd_o.load_out  = out_free;
      cmd_o.save_pend = 1'b0;
    end else begin
      cmd_o.load_out  = finish && out_free;
      cmd_o.save_pend = finish && !out_free;
    end
  end

  // Output valid: set on load, drop when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out)   out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bda_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == bda_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;

  // A result is parked only while the output register is occupied and stalled
  a_pend_only_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.save_pend |-> (out_valid_q && !out_ready_i))
    else $error("result parked while output register free");

  // A parked result never coexists with an empty output register
  a_hold_has_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bda_pkg::S_HOLD) |-> out_valid_q)
    else $error("holding a result with no output pending");

  // An accepted read moves to the store wait state in the next cycle
  a_read_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && sts_i.is_read) |=> (state_q == bda_pkg::S_READ))
    else $error("read not followed by store wait");

  // The last fill step leaves the fill state
  a_fill_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.fill_step && sts_i.fill_last) |=> (state_q != bda_pkg::S_FILL))
    else $error("fill continued past its last slot");

  // A loaded result is presented in the next cycle
  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |=> out_valid_q)
    else $error("loaded result not presented");

endmodule

FILE: hdl/bounded_dynamic_array.sv
// Bounded dynamic array: read, write, push, pop and resize on a 64-word store.
// Result register: loaded from the item decode for write, push, pop and a short resize;
// a read first waits for the registered store read; a growing resize first fills the new slots.
// Throughput: one item per cycle while the output is free; a read or a growing resize
// holds off new items until it is done, and the fill occupies the single store write port.
// Reset clears the length and the output valid; the store is not cleared.
module bounded_dynamic_array (
  input logic       clk_i,
  input logic       rst_ni,
  bda_in_if.sink    in_i,
  bda_out_if.source out_o
);

  bda_pkg::ctrl_cmd_t ctrl_cmd;
  bda_pkg::ctrl_sts_t ctrl_sts;

  bda_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (ctrl_sts),
    .cmd_o       (ctrl_cmd)
  );

  bda_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (ctrl_cmd),
    .sts_o            (ctrl_sts),
    .command_i        (in_i.command),
    .index_i          (in_i.index),
    .data_in_i        (in_i.data_in),
    .target_len_i     (in_i.target_len),
    .enable_i         (in_i.enable),
    .read_data_o      (out_o.read_data),
    .current_length_o (out_o.current_length),
    .error_code_o     (out_o.error_code)
  );

endmodule

FILE: sim/tb_bounded_dynamic_array.sv
`timescale 1ns / 100ps
// Self-checking testbench for bounded_dynamic_array: read, write, push, pop and resize.
// Depends on bda_pkg, bda_in_if, bda_out_if and the bounded_dynamic_array RTL.
module tb_bounded_dynamic_array;

  localparam int unsigned RANDOM_ITEMS = 700;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam int unsigned HOLD_AFTER   = 300;
  localparam int unsigned HOLD_CYCLES  = 150;
  localparam int unsigned MAX_PRINTS   = 50;
  localparam int unsigned CMD_CODES    = 1 << bda_pkg::CMD_W;

  typedef struct packed {
    logic [bda_pkg::CMD_W-1:0]   command;
    logic [bda_pkg::INDEX_W-1:0] index;
    logic [bda_pkg::DIN_W-1:0]   data_in;
    logic [bda_pkg::NLEN_W-1:0]  target_len;
    logic                        enable;
  } array_op_t;

  typedef struct packed {
    logic [bda_pkg::RDATA_W-1:0] read_data;
    logic [bda_pkg::CLEN_W-1:0]  current_length;
    logic [bda_pkg::ERR_W-1:0]   error_code;
  } array_result_t;

  typedef struct packed {
    logic [bda_pkg::DEPTH-1:0][bda_pkg::DATA_WIDTH-1:0] words;
    logic [bda_pkg::CLEN_W-1:0]                         len;
  } array_image_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  bda_in_if  in_if ();
  bda_out_if out_if ();

  bounded_dynamic_array dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Drive every block input from a known value at time zero
  logic      send_valid = 1'b0;
  array_op_t send_op    = '0;
  logic      take_ready = 1'b0;

  assign in_if.valid      = send_valid;
  assign in_if.command    = send_op.command;
  assign in_if.index      = send_op.index;
  assign in_if.data_in    = send_op.data_in;
  assign in_if.target_len = send_op.target_len;
  assign in_if.enable     = send_op.enable;
  assign out_if.ready     = take_ready;

  array_op_t     pending_ops[$];
  array_result_t expected_results[$];
  array_image_t  plan_array;
  array_image_t  shadow_array;
  int unsigned   items_offered  = 0;
  int unsigned   items_accepted = 0;
  int unsigned   results_seen   = 0;
  int unsigned   error_count    = 0;
  int unsigned   idle_cycles    = 0;
  int unsigned   total_items;

  always #5 clk_i = ~clk_i;

  // Apply one command to an array image and return the result it produces
  function automatic array_result_t apply_command(inout array_image_t img, input array_op_t op);
    array_result_t r;
    int unsigned   i;
    r = '0;
    r.error_code = bda_pkg::ERR_OK;
    case (op.command)
      bda_pkg::CMD_READ: begin
        if (op.index < img.len) r.read_data = img.words[op.index];
        else r.error_code = bda_pkg::ERR_BOUNDS;
      end
      bda_pkg::CMD_WRITE: begin
        if (op.index < img.len) img.words[op.index] = op.data_in;
        else r.error_code = bda_pkg::ERR_BOUNDS;
      end
      bda_pkg::CMD_PUSH: begin
        if (img.len >= bda_pkg::DEPTH) begin
          r.error_code = bda_pkg::ERR_FULL;
        end else begin
          img.words[img.len[bda_pkg::ADDR_W-1:0]] = op.data_in;
          img.len = img.len + bda_pkg::CLEN_W'(op.enable);
        end
      end
      bda_pkg::CMD_POP: begin
        if (img.len == 0) r.error_code = bda_pkg::ERR_EMPTY;
        else img.len = img.len - bda_pkg::CLEN_W'(op.enable);
      end
      bda_pkg::CMD_RESIZE: begin
        if (op.target_len > bda_pkg::DEPTH) begin
          r.error_code = bda_pkg::ERR_TOO_LARGE;
        end else begin
          for (i = img.len; i < op.target_len; i++)
            img.words[bda_pkg::ADDR_W'(i)] = op.data_in;
          img.len = op.target_len;
        end
      end
      default: ;
    endcase
    r.current_length = img.len;
    return r;
  endfunction

  function automatic array_op_t make_op(logic [bda_pkg::CMD_W-1:0] cmd,
                                        logic [bda_pkg::INDEX_W-1:0] idx,
                                        logic [bda_pkg::DIN_W-1:0] data,
                                        logic [bda_pkg::NLEN_W-1:0] nlen,
                                        logic en);
    array_op_t op;
    op.command    = cmd;
    op.index      = idx;
    op.data_in    = data;
    op.target_len = nlen;
    op.enable     = en;
    return op;
  endfunction

  // Queue an item and advance the planning image so later items can aim at the length
  task automatic queue_op(input array_op_t op);
    void'(apply_command(plan_array, op));
    pending_ops.push_back(op);
  endtask

  function automatic int unsigned gap_length();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  function automatic logic [bda_pkg::DIN_W-1:0] random_word();
    int unsigned roll;
    roll = $urandom_range(9);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return bda_pkg::DIN_W'($urandom());
  endfunction

  // Build one random item, mostly aimed at the live part of the array
  function automatic array_op_t random_op(logic [bda_pkg::CLEN_W-1:0] len);
    array_op_t   op;
    int unsigned roll;
    int unsigned lo;
    int unsigned hi;
    op.command    = bda_pkg::CMD_READ;
    op.data_in    = random_word();
    op.target_len = bda_pkg::NLEN_W'($urandom_range((1 << bda_pkg::NLEN_W) - 1));
    op.enable     = ($urandom_range(99) < 85);
    if (len != 0 && $urandom_range(99) < 80) op.index = bda_pkg::INDEX_W'($urandom_range(len - 1));
    else op.index = bda_pkg::INDEX_W'($urandom_range(bda_pkg::DEPTH - 1));
    roll = $urandom_range(99);
    if (roll < 24) begin
      op.command = bda_pkg::CMD_READ;
    end else if (roll < 44) begin
      op.command = bda_pkg::CMD_WRITE;
    end else if (roll < 64) begin
      op.command = (len > 48 && $urandom_range(1)) ? bda_pkg::CMD_POP : bda_pkg::CMD_PUSH;
    end else if (roll < 80) begin
      op.command = (len < 8 && $urandom_range(1)) ? bda_pkg::CMD_PUSH : bda_pkg::CMD_POP;
    end else if (roll < 96) begin
      op.command = bda_pkg::CMD_RESIZE;
      roll = $urandom_range(9);
      if (roll == 0) begin
        op.target_len = '0;
      end else if (roll == 1) begin
        op.target_len = bda_pkg::NLEN_W'(bda_pkg::DEPTH);
      end else if (roll == 2) begin
        op.target_len = bda_pkg::NLEN_W'($urandom_range((1 << bda_pkg::NLEN_W) - 1,
                                                        bda_pkg::DEPTH + 1));
      end else begin
        lo = (len > 8) ? len - 8 : 0;
        hi = (len + 8 < bda_pkg::DEPTH) ? len + 8 : bda_pkg::DEPTH;
        op.target_len = bda_pkg::NLEN_W'($urandom_range(hi, lo));
      end
    end else begin
      op.command = bda_pkg::CMD_W'($urandom_range(CMD_CODES - 1,
                                                  int'(bda_pkg::CMD_RESIZE) + 1));
    end
    return op;
  endfunction

  task automatic flag_error(input string msg);
    if (error_count < MAX_PRINTS) $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  // Stimulus, reset and end of run
  initial begin
    int unsigned c;
    plan_array   = '0;
    shadow_array = '0;

    // Directed: empty pop, failed write, disabled push, bounds, full, too large, shrink
    queue_op(make_op(bda_pkg::CMD_POP,    '0,  '0,           '0,  1'b1));
    queue_op(make_op(bda_pkg::CMD_POP,    '0,  '1,           '0,  1'b0));
    queue_op(make_op(bda_pkg::CMD_WRITE,  '1,  '1,           '0,  1'b1));
    queue_op(make_op(bda_pkg::CMD_PUSH,   '0,  '1,           '0,  1'b0));
    queue_op(make_op(bda_pkg::CMD_PUSH,   '0,  '0,           '0,  1'b1));
    queue_op(make_op(bda_pkg::CMD_PUSH,   '0,  32'hA5A5A5A5, '0,  1'b1));
    queue_op(make_op(bda_pkg::CMD_READ,   '0,  '0,           '0,  1'b0));
    queue_op(make_op(bda_pkg::CMD_WRITE,  6'd1, '1,          '0,  1'b0));
    queue_op(make_op(bda_pkg::CMD_READ,   6'd1, '0,          '1,  1'b1));
    queue_op(make_op(bda_pkg::CMD_POP,    '0,  '0,           '0,  1'b0));
    queue_op(make_op(bda_pkg::CMD_POP,    '0,  '0,           '0,  1'b1));
    queue_op(make_op(bda_pkg::CMD_READ,   6'd1, '0,          '0,  1'b1));
    queue_op(make_op(bda_pkg::CMD_RESIZE, '0,  '1,           '1,  1'b1));
    queue_op(make_op(bda_pkg::CMD_RESIZE, '0,  '1,
                     bda_pkg::NLEN_W'(bda_pkg::DEPTH + 1), 1'b1));
    queue_op(make_op(bda_pkg::CMD_RESIZE, '0,  32'h5A5A5A5A,
                     bda_pkg::NLEN_W'(bda_pkg::DEPTH), 1'b0));
    queue_op(make_op(bda_pkg::CMD_PUSH,   '0,  '1,           '0,  1'b1));
    queue_op(make_op(bda_pkg::CMD_PUSH,   '0,  '1,           '0,  1'b0));
    queue_op(make_op(bda_pkg::CMD_READ,   '1,  '0,           '0,  1'b0));
    queue_op(make_op(bda_pkg::CMD_WRITE,  '1,  '0,           '0,  1'b1));
    queue_op(make_op(bda_pkg::CMD_RESIZE, '0,  '0,           7'd3, 1'b1));
    queue_op(make_op(bda_pkg::CMD_READ,   6'd40, '0,         '0,  1'b1));
    queue_op(make_op(bda_pkg::CMD_WRITE,  6'd2, '1,          '0,  1'b1));
    for (c = int'(bda_pkg::CMD_RESIZE) + 1; c < CMD_CODES; c++) begin
      queue_op(make_op(bda_pkg::CMD_W'(c), '1, '1, '1, 1'b1));
    end
    queue_op(make_op(bda_pkg::CMD_RESIZE, '0,  '1,           '0,  1'b1));

    // Random part; every slot has been written by the pushes and the full resize above
    repeat (RANDOM_ITEMS) queue_op(random_op(plan_array.len));
    total_items = pending_ops.size();

    // Hold reset, release it away from the rising edge
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Wait for every item to go in and every result to come back, then drain
    while (items_accepted != total_items || expected_results.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Driver: present the next item once the last one is taken, with random gaps
  int unsigned send_gap  = 0;
  int unsigned send_calm = 0;

  always @(negedge clk_i) begin
    if (rst_ni && !(send_valid && items_offered != items_accepted)) begin
      if (send_gap > 0) begin
        send_gap--;
        send_valid <= 1'b0;
      end else if (pending_ops.size() > 0) begin
        send_op    <= pending_ops.pop_front();
        send_valid <= 1'b1;
        items_offered++;
        if (send_calm > 0) send_calm--;
        else if ($urandom_range(99) < 3) send_calm = 40;
        else send_gap = gap_length();
      end else begin
        send_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off to back the block up
  int unsigned take_stall = 0;
  int unsigned take_calm  = 0;
  logic        hold_done  = 1'b0;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!hold_done && results_seen >= HOLD_AFTER) begin
        hold_done  = 1'b1;
        take_stall = HOLD_CYCLES;
        take_ready <= 1'b0;
      end else if (take_stall > 0) begin
        take_stall--;
        take_ready <= 1'b0;
      end else begin
        take_ready <= 1'b1;
        if (take_calm > 0) take_calm--;
        else if ($urandom_range(99) < 3) take_calm = 60;
        else take_stall = gap_length();
      end
    end
  end

  // Monitor: record accepted items, check results in order, watch for a hang
  array_op_t     taken_op;
  array_result_t want;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        taken_op.command    = in_if.command;
        taken_op.index      = in_if.index;
        taken_op.data_in    = in_if.data_in;
        taken_op.target_len = in_if.target_len;
        taken_op.enable     = in_if.enable;
        expected_results.push_back(apply_command(shadow_array, taken_op));
        items_accepted++;
      end
      if (out_if.valid && out_if.ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          flag_error("result arrived with no item outstanding");
        end else begin
          want = expected_results.pop_front();
          if (out_if.read_data !== want.read_data)
            flag_error($sformatf("result %0d read_data %h, expected %h",
                                 results_seen, out_if.read_data, want.read_data));
          if (out_if.current_length !== want.current_length)
            flag_error($sformatf("result %0d current_length %0d, expected %0d",
                                 results_seen, out_if.current_length, want.current_length));
          if (out_if.error_code !== want.error_code)
            flag_error($sformatf("result %0d error_code %0d, expected %0d",
                                 results_seen, out_if.error_code, want.error_code));
        end
      end
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("ERROR @%0t: no progress for %0d cycles", $time, STALL_LIMIT);
          $display("Testbench completed WITH ERRORS");
          $finish;
        end
      end
    end
  end

endmodule
